/* src/ofd_pkg.sv */
// shared types, constants and the cell classifier for the frontier detector
package ofd_pkg;

  // fixed field and register widths
  localparam int CFG_W   = 11;
  localparam int LIMIT_W = 7;
  localparam int OCC_W   = 8;
  localparam int COORD_W = 10;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int MIN_SIZE = 3;

  // register reset values
  localparam logic [CFG_W-1:0]   WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_W-1:0]   HEIGHT_RESET = 11'd1024;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 7'd50;

  // occupancy code for an unknown cell (-1)
  localparam logic [OCC_W-1:0] OCC_UNKNOWN = 8'hFF;

  // cell classes
  typedef enum logic [1:0] {
    CLS_OTHER   = 2'd0,
    CLS_FREE    = 2'd1,
    CLS_UNKNOWN = 2'd2
  } cls_t;

  // register indexes on the config port
  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_FREE_LIMIT  = 2'd2
  } reg_idx_t;

  // 3x3 window of classes, element 0 is the newest row-bottom entry
  typedef logic [8:0][1:0] window_t;

  // one request after the input register
  typedef struct packed {
    logic               emit;
    logic               frame_last;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [1:0]         cls;
  } item_t;

  // class of one occupancy value
  function automatic logic [1:0] classify(input logic [OCC_W-1:0] occ,
                                          input logic [LIMIT_W-1:0] limit);
    logic [1:0] cls;
    cls = CLS_OTHER;
    if (occ == OCC_UNKNOWN) begin
      cls = CLS_UNKNOWN;
    end else if (!occ[OCC_W-1] && (occ[LIMIT_W-1:0] < limit)) begin
      cls = CLS_FREE;
    end
    return cls;
  endfunction

endpackage

/* src/ofd_regs.sv */
// config register file on the apb-style port
module ofd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ofd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ofd_pkg::DATA_W-1:0]   pwdata,
  output logic [ofd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [ofd_pkg::CFG_W-1:0]    grid_width,
  output logic [ofd_pkg::CFG_W-1:0]    grid_height,
  output logic [ofd_pkg::LIMIT_W-1:0]  free_limit,
  output logic                         restart
);
  import ofd_pkg::*;

  logic     wr;
  reg_idx_t sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = reg_idx_t'(paddr[ADDR_W-1:2]);

  // a write to the width or height restarts the frame
  assign restart = wr && ((sel == REG_GRID_WIDTH) || (sel == REG_GRID_HEIGHT));

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= WIDTH_RESET;
      grid_height <= HEIGHT_RESET;
      free_limit  <= LIMIT_RESET;
    end else if (wr) begin
      case (sel)
        REG_GRID_WIDTH:  grid_width  <= pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[CFG_W-1:0];
        REG_FREE_LIMIT:  free_limit  <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (sel)
      REG_GRID_WIDTH:  prdata = DATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = DATA_W'(grid_height);
      REG_FREE_LIMIT:  prdata = DATA_W'(free_limit);
      default:         prdata = '0;
    endcase
  end

endmodule

/* src/ofd_linebuf.sv */
// two line stores of cell classes with registered reads
module ofd_linebuf #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [1:0]               wr_upper,
  input  logic [1:0]               wr_middle,
  output logic [1:0]               rd_upper,
  output logic [1:0]               rd_middle
);

  logic [1:0] upper_mem  [DEPTH];
  logic [1:0] middle_mem [DEPTH];

  // write port, one entry per request leaving the input stage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  // read port, captured on input accept
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
  end

endmodule

/* src/ofd_window.sv */
// 3x3 class window, frontier decision and result register
module ofd_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        restart,
  input  logic                        s1_valid,
  input  ofd_pkg::item_t              s1_item,
  input  logic [1:0]                  rd_upper,
  input  logic [1:0]                  rd_middle,
  output logic                        s1_advance,
  output logic                        cell_valid,
  input  logic                        cell_ready,
  output logic [ofd_pkg::COORD_W-1:0] cell_col,
  output logic [ofd_pkg::COORD_W-1:0] cell_row,
  output logic                        is_frontier,
  output logic                        frame_last
);
  import ofd_pkg::*;

  window_t window;
  window_t window_next;
  logic    unk;
  logic    frontier;

  // the input stage moves on whenever the result slot is free or draining
  assign s1_advance = s1_valid && (!cell_valid || cell_ready);

  // shift in the new column: upper, middle, current row
  assign window_next = {window[5:0], rd_upper, rd_middle, s1_item.cls};

  // any unknown among the eight neighbours of the center
  always_comb begin
    unk = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4 && window_next[k] == CLS_UNKNOWN) begin
        unk = 1'b1;
      end
    end
    frontier = (window_next[4] == CLS_FREE) && unk;
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      window <= '0;
    end else if (s1_advance) begin
      window <= window_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (s1_advance) begin
      cell_valid <= s1_item.emit;
    end else if (cell_ready) begin
      cell_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_advance && s1_item.emit) begin
      cell_col    <= s1_item.col;
      cell_row    <= s1_item.row;
      is_frontier <= frontier;
      frame_last  <= s1_item.frame_last;
    end
  end

endmodule

/* src/occupancy_frontier_detect.sv */
// top level of the occupancy grid frontier detector
//
// Cells of an occupancy grid enter on the occupancy channel (valid/ready) in
// raster order, one signed byte per request. Each interior cell leaves on the
// cell channel (valid/ready) with its column, row, a frontier flag and a mark
// on the last interior cell of the frame; border cells give no result.
// Grid size and the free limit are set over the apb-style port; writing the
// width or height restarts the frame at row 0, column 0.
// One cell is taken every cycle while the receiver takes results. A cell's result
// comes out of the result register after the request that completes its 3x3
// neighborhood (the cell one row down and one column right) has passed the
// input stage with the line-store read. The single read port of each line
// store and the one-column window shift set the rate of one cell per cycle.
// When the receiver stalls, the result register holds and the input stage
// keeps one more cell; ready drops only while both are full.
// Synchronous reset clears the counters, window and valid flags and loads the
// register defaults; the line stores are not cleared, since an entry is read
// for a decision only after it was written within the frame.
module occupancy_frontier_detect #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ofd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ofd_pkg::DATA_W-1:0]   pwdata,
  output logic [ofd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         occupancy_valid,
  output logic                         occupancy_ready,
  input  logic signed [ofd_pkg::OCC_W-1:0] occupancy,
  output logic                         cell_valid,
  input  logic                         cell_ready,
  output logic [ofd_pkg::COORD_W-1:0]  cell_col,
  output logic [ofd_pkg::COORD_W-1:0]  cell_row,
  output logic                         is_frontier,
  output logic                         frame_last
);
  import ofd_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WCMP  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HCMP  = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int CEXT  = (AW > COORD_W) ? AW : COORD_W;
  localparam int REXT  = (RW > COORD_W) ? RW : COORD_W;

  logic [CFG_W-1:0]   grid_width;
  logic [CFG_W-1:0]   grid_height;
  logic [LIMIT_W-1:0] free_limit;
  logic               restart;

  logic [WCMP-1:0] w_raw;
  logic [WCMP-1:0] w_eff;
  logic [HCMP-1:0] h_raw;
  logic [HCMP-1:0] h_eff;

  logic [AW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic          accept;
  logic          col_wrap;
  logic          row_wrap;
  logic [CEXT-1:0] col_m1;
  logic [REXT-1:0] row_m1;

  logic          s1_valid;
  logic          s1_advance;
  item_t         s1_item;
  item_t         s1_item_next;
  logic [AW-1:0] s1_addr;
  logic [1:0]    rd_upper;
  logic [1:0]    rd_middle;

  ofd_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .free_limit  (free_limit),
    .restart     (restart)
  );

  // clamp the grid size to 3..max
  always_comb begin
    w_raw = WCMP'(grid_width);
    h_raw = HCMP'(grid_height);
    if (w_raw < WCMP'(MIN_SIZE)) begin
      w_eff = WCMP'(MIN_SIZE);
    end else if (w_raw > WCMP'(MAX_WIDTH)) begin
      w_eff = WCMP'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < HCMP'(MIN_SIZE)) begin
      h_eff = HCMP'(MIN_SIZE);
    end else if (h_raw > HCMP'(MAX_HEIGHT)) begin
      h_eff = HCMP'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // input handshake
  assign occupancy_ready = !s1_valid || s1_advance;
  assign accept          = occupancy_valid && occupancy_ready;

  // end of row and end of frame
  assign col_wrap = (WCMP'(column_count) + WCMP'(1)) >= w_eff;
  assign row_wrap = (HCMP'(row_count) + HCMP'(1)) >= h_eff;

  // raster position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_count + RW'(1);
      end else begin
        column_count <= column_count + AW'(1);
      end
    end
  end

  // request fields for the input stage
  always_comb begin
    col_m1 = CEXT'(column_count) - CEXT'(1);
    row_m1 = REXT'(row_count) - REXT'(1);
    s1_item_next.emit       = (column_count >= AW'(2)) && (row_count >= RW'(2));
    s1_item_next.frame_last = col_wrap && row_wrap;
    s1_item_next.col        = col_m1[COORD_W-1:0];
    s1_item_next.row        = row_m1[COORD_W-1:0];
    s1_item_next.cls        = classify(occupancy, free_limit);
  end

  // input stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= s1_item_next;
      s1_addr <= column_count;
    end
  end

  ofd_linebuf #(
    .DEPTH (MAX_WIDTH)
  ) u_linebuf (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (column_count),
    .wr_en     (s1_advance),
    .wr_addr   (s1_addr),
    .wr_upper  (rd_middle),
    .wr_middle (s1_item.cls),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  ofd_window u_window (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .s1_valid    (s1_valid),
    .s1_item     (s1_item),
    .rd_upper    (rd_upper),
    .rd_middle   (rd_middle),
    .s1_advance  (s1_advance),
    .cell_valid  (cell_valid),
    .cell_ready  (cell_ready),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .is_frontier (is_frontier),
    .frame_last  (frame_last)
  );

endmodule

/* verif/tb_occupancy_frontier_detect.sv */
// testbench for the occupancy frontier detector: streamed grids checked against a cell predictor
`timescale 1ns / 100ps

module tb_occupancy_frontier_detect;
  import ofd_pkg::*;

  localparam int GRID_MAX      = 1024;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PRESSURE_HOLD = 300;
  localparam int RANDOM_CELLS  = 330;
  localparam int EDGE_CELLS    = 48;
  localparam int MAX_REPORTS   = 100;

  // one decided interior cell
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               frontier;
    logic               last;
  } cell_result_t;

  logic clk;
  logic rst = 1'b1;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic                    occupancy_valid = 1'b0;
  logic                    occupancy_ready;
  logic signed [OCC_W-1:0] occupancy = '0;
  logic                    cell_valid;
  logic                    cell_ready = 1'b0;
  logic [COORD_W-1:0]      cell_col;
  logic [COORD_W-1:0]      cell_row;
  logic                    is_frontier;
  logic                    frame_last;

  // stimulus and expectation stores
  logic [OCC_W-1:0] pending_cells[$];
  cell_result_t     expected_cells[$];
  int               errors = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  logic             pressure_go = 1'b0;
  logic             rx_hold = 1'b0;

  // predictor state
  logic [CFG_W-1:0]   cfg_width  = WIDTH_RESET;
  logic [CFG_W-1:0]   cfg_height = HEIGHT_RESET;
  logic [LIMIT_W-1:0] cfg_limit  = LIMIT_RESET;
  cls_t               upper_cls[GRID_MAX];
  cls_t               middle_cls[GRID_MAX];
  logic [17:0]        nbr_window = '0;
  int unsigned        col_cnt = 0;
  int unsigned        row_cnt = 0;

  occupancy_frontier_detect i_dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .occupancy_valid (occupancy_valid),
    .occupancy_ready (occupancy_ready),
    .occupancy       (occupancy),
    .cell_valid      (cell_valid),
    .cell_ready      (cell_ready),
    .cell_col        (cell_col),
    .cell_row        (cell_row),
    .is_frontier     (is_frontier),
    .frame_last      (frame_last)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // append to the tail of the request and result queues
  function automatic void add_pending(input logic [OCC_W-1:0] occ);
    pending_cells = {pending_cells, occ};
  endfunction

  function automatic void add_expected(input cell_result_t res);
    expected_cells = {expected_cells, res};
  endfunction

  // effective grid size after clamping
  function automatic int unsigned grid_size(input logic [CFG_W-1:0] v);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > GRID_MAX) return GRID_MAX;
    return v;
  endfunction

  function automatic void restart_frame();
    col_cnt = 0;
    row_cnt = 0;
    nbr_window = '0;
  endfunction

  // advance the frame by one accepted cell and queue its decision, if any
  function automatic void predict_cell(input logic [OCC_W-1:0] occ);
    int unsigned  w;
    int unsigned  h;
    int           k;
    cls_t         cls;
    cls_t         up;
    cls_t         mid;
    logic         touch;
    cell_result_t res;
    w = grid_size(cfg_width);
    h = grid_size(cfg_height);
    cls = CLS_OTHER;
    if (occ == OCC_UNKNOWN) begin
      cls = CLS_UNKNOWN;
    end else if (!occ[OCC_W-1] && (occ < {1'b0, cfg_limit})) begin
      cls = CLS_FREE;
    end
    up  = upper_cls[col_cnt];
    mid = middle_cls[col_cnt];
    nbr_window = {nbr_window[11:0], up, mid, cls};
    // the window is centered one row up, one column left of this cell
    if (col_cnt >= 2 && row_cnt >= 2) begin
      touch = 1'b0;
      for (k = 0; k < 9; k++) begin
        if (k != 4 && nbr_window[2*k +: 2] == CLS_UNKNOWN) touch = 1'b1;
      end
      res.col      = COORD_W'(col_cnt - 1);
      res.row      = COORD_W'(row_cnt - 1);
      res.frontier = (nbr_window[9:8] == CLS_FREE) && touch;
      res.last     = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
      add_expected(res);
    end
    upper_cls[col_cnt]  = mid;
    middle_cls[col_cnt] = cls;
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
  endfunction

  // occupancy mix: many unknown and free values so frontiers are common
  function automatic logic [OCC_W-1:0] random_occupancy(input logic [LIMIT_W-1:0] limit);
    case ($urandom_range(9))
      0, 1, 2: return OCC_UNKNOWN;
      3, 4, 5: return (limit == 0) ? '0 : OCC_W'($urandom_range(limit - 1));
      6:       return OCC_W'($urandom_range(127));
      default: return OCC_W'($urandom);
    endcase
  endfunction

  task automatic push_random(input int n);
    repeat (n) add_pending(random_occupancy(cfg_limit));
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 52;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 52;
      end
      default: begin
        send_idle_pct = 13;
        recv_stall_pct = 13;
      end
    endcase
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GRID_WIDTH: begin
        cfg_width = value[CFG_W-1:0];
        restart_frame();
      end
      REG_GRID_HEIGHT: begin
        cfg_height = value[CFG_W-1:0];
        restart_frame();
      end
      REG_FREE_LIMIT: cfg_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // drain all requests and results, then let the pipeline empty
  task automatic wait_idle();
    while (pending_cells.size() != 0 || occupancy_valid) @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : drive_cells
    if (rst) begin
      occupancy_valid <= 1'b0;
    end else begin
      if (occupancy_valid && occupancy_ready) predict_cell(occupancy);
      if (!occupancy_valid || occupancy_ready) begin
        if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          occupancy_valid <= 1'b1;
          occupancy       <= pending_cells.pop_front();
        end else begin
          occupancy_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : check_cells
    cell_result_t want;
    if (rst) begin
      cell_ready <= 1'b0;
    end else begin
      if (cell_valid && cell_ready) begin
        if (expected_cells.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected cell result col %0d row %0d frontier %0b last %0b",
                     $time, cell_col, cell_row, is_frontier, frame_last);
        end else begin
          want = expected_cells.pop_front();
          if (cell_col !== want.col || cell_row !== want.row ||
              is_frontier !== want.frontier || frame_last !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"%0t: expected col %0d row %0d frontier %0b last %0b, ",
                        "got col %0d row %0d frontier %0b last %0b"},
                       $time, want.col, want.row, want.frontier, want.last,
                       cell_col, cell_row, is_frontier, frame_last);
          end
        end
      end
      cell_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (PRESSURE_HOLD) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // run limit
  initial begin
    #200_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus sequence
  initial begin
    logic [OCC_W-1:0]   directed_grid[20];
    logic [OCC_W-1:0]   cross_grid[9];
    logic [CFG_W-1:0]   wv;
    logic [CFG_W-1:0]   hv;
    logic [LIMIT_W-1:0] lv;
    int                 random_cells;
    int                 phase;
    int                 frame_cells;
    directed_grid = '{8'hFF, 8'h00, 8'h7F, 8'h80, 8'd49,
                      8'h00, 8'h00, 8'd50, 8'd1,  8'hFF,
                      8'd100, 8'hFE, 8'h00, 8'd49, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'hFF, 8'h00};
    cross_grid = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF};
    foreach (upper_cls[i]) begin
      upper_cls[i]  = CLS_OTHER;
      middle_cls[i] = CLS_OTHER;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed 5x4 grid: value extremes, class boundaries at the reset free limit
    write_reg(REG_GRID_WIDTH, 5);
    write_reg(REG_GRID_HEIGHT, 4);
    foreach (directed_grid[i]) add_pending(directed_grid[i]);
    wait_idle();

    // sizes below the minimum clamp to 3x3; a zero free limit makes nothing free
    write_reg(REG_FREE_LIMIT, 0);
    write_reg(REG_GRID_WIDTH, 0);
    write_reg(REG_GRID_HEIGHT, 2);
    foreach (cross_grid[i]) add_pending(cross_grid[i]);
    wait_idle();

    // random frames, partial frames and limit changes mid-frame
    random_cells = 0;
    phase = 0;
    while (random_cells < RANDOM_CELLS) begin
      set_idle(phase % 4);
      lv = (phase == 0) ? 7'd127 : (phase == 1) ? 7'd1 : LIMIT_W'($urandom_range(1, 127));
      write_reg(REG_FREE_LIMIT, DATA_W'(lv));
      if (phase % 5 != 4) begin
        case ($urandom_range(7))
          0:       wv = CFG_W'($urandom_range(2));
          1:       wv = CFG_W'($urandom_range(13, 40));
          default: wv = CFG_W'($urandom_range(3, 12));
        endcase
        hv = ($urandom_range(5) == 0) ? CFG_W'($urandom_range(2)) : CFG_W'($urandom_range(3, 6));
        write_reg(REG_GRID_WIDTH, DATA_W'(wv));
        write_reg(REG_GRID_HEIGHT, DATA_W'(hv));
      end
      frame_cells = grid_size(cfg_width) * grid_size(cfg_height);
      frame_cells = frame_cells + $urandom_range(frame_cells);
      if (frame_cells > RANDOM_CELLS - random_cells) frame_cells = RANDOM_CELLS - random_cells;
      push_random(frame_cells);
      random_cells += frame_cells;
      wait_idle();
      phase++;
    end

    // back-pressure: receiver held off while requests keep coming
    set_idle(0);
    write_reg(REG_GRID_WIDTH, 8);
    write_reg(REG_GRID_HEIGHT, 6);
    pressure_go = 1'b1;
    push_random(96);
    wait_idle();

    // wide grid: width register all ones clamps to the maximum, start of the first row
    set_idle(3);
    write_reg(REG_GRID_WIDTH, 2047);
    write_reg(REG_GRID_HEIGHT, 3);
    push_random(EDGE_CELLS);
    wait_idle();

    // tall grid: height register all ones clamps to the maximum, first rows of three cells
    set_idle(1);
    write_reg(REG_GRID_WIDTH, 0);
    write_reg(REG_GRID_HEIGHT, 2047);
    push_random(EDGE_CELLS);
    wait_idle();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
